// ----- rtl/core/cia_pkg.sv -----
// Shared types and codes of the complex integer ALU.
package cia_pkg;

    localparam int FIELD_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int CMD_W         = 3;
    localparam int CELL_BITS_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MAG = 3'd4
    } cmd_e;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIVZ = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

    // Control that travels alongside each request through the front end and the cells
    typedef struct packed {
        logic valid;
        cmd_e op;
        logic dz;
        logic ovf_re;
        logic ovf_im;
        logic neg_re;
        logic neg_im;
    } ctl_t;

endpackage

// ----- rtl/core/complex_integer_alu.sv -----
// Top level of the complex integer ALU: front end, cell chain, rounding and output skid.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------
//  request | in_valid  | in_stall  | cmd, a_real, a_imag, b_real, b_imag
//  result  | out_valid | out_stall | res_real, res_imag, status
//
//  Depth: five front-end stages, CELL_BITS + 1 cells and one output register;
//  one request enters every cycle while in_stall is low.
//  The cell chain sets the depth: each cell settles one quotient bit of both
//  parts and one digit of the square root.
//  Reset clears every valid bit; no clearing pass is needed.
//  A stalled result parks the next one in the skid register; only a full skid
//  register holds the chain and raises in_stall.
module complex_integer_alu #(
    parameter int CELL_BITS = cia_pkg::CELL_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [cia_pkg::CMD_W-1:0]    cmd,
    input  logic signed [cia_pkg::FIELD_W-1:0] a_real,
    input  logic signed [cia_pkg::FIELD_W-1:0] a_imag,
    input  logic signed [cia_pkg::FIELD_W-1:0] b_real,
    input  logic signed [cia_pkg::FIELD_W-1:0] b_imag,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [cia_pkg::FIELD_W-1:0] res_real,
    output logic signed [cia_pkg::FIELD_W-1:0] res_imag,
    output logic [cia_pkg::STATUS_W-1:0] status
);
    import cia_pkg::*;

    localparam int W   = CELL_BITS;
    localparam int DW  = 2 * W;
    localparam int RW  = 2 * W + 1;
    localparam int SW  = 2 * W + 2;
    localparam int SRW = W + 2;
    localparam int NC  = W + 1;
    localparam logic [W+1:0] POS_LIM = ((W+2)'(1) << (W - 1)) - 1'b1;
    localparam logic [W+1:0] NEG_LIM = (W+2)'(1) << (W - 1);

    logic pipe_en;

    // chain taps: index 0 is the front end, index k+1 the output of cell k
    ctl_t           c_ctl    [NC+1];
    logic [DW-1:0]  c_d      [NC+1];
    logic [RW-1:0]  c_rem_re [NC+1];
    logic [RW-1:0]  c_rem_im [NC+1];
    logic [W:0]     c_nq_re  [NC+1];
    logic [W:0]     c_nq_im  [NC+1];
    logic [SW-1:0]  c_s_lo   [NC+1];
    logic [SRW-1:0] c_s_rem  [NC+1];
    logic [W:0]     c_root   [NC+1];
    logic [W-1:0]   c_dre    [NC+1];
    logic [W-1:0]   c_dim    [NC+1];

    assign c_s_rem[0] = '0;
    assign c_root[0]  = '0;

    cia_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .valid     (in_valid),
        .cmd       (cmd),
        .ar        (a_real[W-1:0]),
        .ai        (a_imag[W-1:0]),
        .br        (b_real[W-1:0]),
        .bi        (b_imag[W-1:0]),
        .ctl       (c_ctl[0]),
        .d         (c_d[0]),
        .rem_re    (c_rem_re[0]),
        .rem_im    (c_rem_im[0]),
        .nq_re     (c_nq_re[0]),
        .nq_im     (c_nq_im[0]),
        .s_lo      (c_s_lo[0]),
        .direct_re (c_dre[0]),
        .direct_im (c_dim[0])
    );

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        cia_cell #(.W(W)) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .en             (pipe_en),
            .prev_ctl       (c_ctl[k]),
            .prev_d         (c_d[k]),
            .prev_rem_re    (c_rem_re[k]),
            .prev_rem_im    (c_rem_im[k]),
            .prev_nq_re     (c_nq_re[k]),
            .prev_nq_im     (c_nq_im[k]),
            .prev_s_lo      (c_s_lo[k]),
            .prev_s_rem     (c_s_rem[k]),
            .prev_root      (c_root[k]),
            .prev_direct_re (c_dre[k]),
            .prev_direct_im (c_dim[k]),
            .ctl            (c_ctl[k+1]),
            .d              (c_d[k+1]),
            .rem_re         (c_rem_re[k+1]),
            .rem_im         (c_rem_im[k+1]),
            .nq_re          (c_nq_re[k+1]),
            .nq_im          (c_nq_im[k+1]),
            .s_lo           (c_s_lo[k+1]),
            .s_rem          (c_s_rem[k+1]),
            .root           (c_root[k+1]),
            .direct_re      (c_dre[k+1]),
            .direct_im      (c_dim[k+1])
        );
    end

    // Rounding and saturation of the finished item at the end of the chain
    ctl_t                 fin_ctl;
    logic                 rnd_re, rnd_im, sat_re, sat_im, sat_m;
    logic [W+1:0]         q_re, q_im, lim_re, lim_im, m_re, m_im, r_up, m_mag;
    logic [W+1:0]         v_re, v_im;
    logic [W-1:0]         fin_re, fin_im;
    logic [STATUS_W-1:0]  fin_st;
    logic                 fire;

    assign fin_ctl = c_ctl[NC];

    always_comb
    begin
        // ties go away from zero: round up when twice the remainder reaches the divisor
        rnd_re = {c_rem_re[NC], 1'b0} >= (RW+1)'(c_d[NC]);
        rnd_im = {c_rem_im[NC], 1'b0} >= (RW+1)'(c_d[NC]);
        q_re   = (W+2)'(c_nq_re[NC]) + (W+2)'(rnd_re);
        q_im   = (W+2)'(c_nq_im[NC]) + (W+2)'(rnd_im);
        lim_re = fin_ctl.neg_re ? NEG_LIM : POS_LIM;
        lim_im = fin_ctl.neg_im ? NEG_LIM : POS_LIM;
        sat_re = fin_ctl.ovf_re || (q_re > lim_re);
        sat_im = fin_ctl.ovf_im || (q_im > lim_im);
        m_re   = sat_re ? lim_re : q_re;
        m_im   = sat_im ? lim_im : q_im;
        v_re   = fin_ctl.neg_re ? (~m_re + 1'b1) : m_re;
        v_im   = fin_ctl.neg_im ? (~m_im + 1'b1) : m_im;

        // root rounds up when the leftover exceeds the root itself
        r_up   = (W+2)'(c_root[NC]) + (W+2)'(c_s_rem[NC] > SRW'(c_root[NC]));
        sat_m  = r_up > POS_LIM;
        m_mag  = sat_m ? POS_LIM : r_up;

        unique case (fin_ctl.op)
            CMD_DIV:
            begin
                if (fin_ctl.dz)
                begin
                    fin_re = '0;
                    fin_im = '0;
                    fin_st = ST_DIVZ;
                end
                else
                begin
                    fin_re = v_re[W-1:0];
                    fin_im = v_im[W-1:0];
                    fin_st = (sat_re || sat_im) ? ST_SAT : ST_OK;
                end
            end
            CMD_MAG:
            begin
                fin_re = m_mag[W-1:0];
                fin_im = '0;
                fin_st = sat_m ? ST_SAT : ST_OK;
            end
            default:
            begin
                fin_re = c_dre[NC];
                fin_im = c_dim[NC];
                fin_st = ST_OK;
            end
        endcase
    end

    // Output register with skid stage
    logic                 out_vld_reg, out_vld_next;
    logic                 skid_vld_reg, skid_vld_next;
    logic [W-1:0]         out_re_reg, out_re_next, out_im_reg, out_im_next;
    logic [STATUS_W-1:0]  out_st_reg, out_st_next;
    logic [W-1:0]         skid_re_reg, skid_re_next, skid_im_reg, skid_im_next;
    logic [STATUS_W-1:0]  skid_st_reg, skid_st_next;
    logic                 out_free;

    assign pipe_en  = !skid_vld_reg;
    assign fire     = pipe_en && fin_ctl.valid;
    assign out_free = !out_vld_reg || !out_stall;

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_re_next   = out_re_reg;
        out_im_next   = out_im_reg;
        out_st_next   = out_st_reg;
        skid_vld_next = skid_vld_reg;
        skid_re_next  = skid_re_reg;
        skid_im_next  = skid_im_reg;
        skid_st_next  = skid_st_reg;
        if (out_free)
        begin
            if (skid_vld_reg)
            begin
                // drain the parked result first
                out_vld_next  = 1'b1;
                out_re_next   = skid_re_reg;
                out_im_next   = skid_im_reg;
                out_st_next   = skid_st_reg;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next = fire;
                out_re_next  = fin_re;
                out_im_next  = fin_im;
                out_st_next  = fin_st;
            end
        end
        else if (fire)
        begin
            // hold the presented result, park the new one
            skid_vld_next = 1'b1;
            skid_re_next  = fin_re;
            skid_im_next  = fin_im;
            skid_st_next  = fin_st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_re_reg  <= out_re_next;
        out_im_reg  <= out_im_next;
        out_st_reg  <= out_st_next;
        skid_re_reg <= skid_re_next;
        skid_im_reg <= skid_im_next;
        skid_st_reg <= skid_st_next;
    end

    logic signed [W-1:0] out_re_s, out_im_s;

    assign out_re_s  = out_re_reg;
    assign out_im_s  = out_im_reg;
    assign in_stall  = !pipe_en;
    assign out_valid = out_vld_reg;
    assign res_real  = FIELD_W'(out_re_s);
    assign res_imag  = FIELD_W'(out_im_s);
    assign status    = out_st_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid register full while output register empty");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && out_stall))
        else $error("result parked although output was free");

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_st_reg == ST_DIVZ) |-> (out_re_reg == '0 && out_im_reg == '0))
        else $error("divide by zero result with non-zero parts");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_st_reg == ST_OK || out_st_reg == ST_DIVZ || out_st_reg == ST_SAT))
        else $error("undefined status code");

    a_root_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        fin_ctl.valid |-> (c_s_lo[NC] == '0))
        else $error("radicand bits left at the end of the chain");

endmodule

// ----- rtl/core/cia_front.sv -----
// Operand front end: products, sums, direct add/sub/mul results, magnitudes and overflow pre-check.
module cia_front #(
    parameter int W = cia_pkg::CELL_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      valid,
    input  logic [cia_pkg::CMD_W-1:0] cmd,
    input  logic signed [W-1:0]       ar,
    input  logic signed [W-1:0]       ai,
    input  logic signed [W-1:0]       br,
    input  logic signed [W-1:0]       bi,
    output cia_pkg::ctl_t             ctl,
    output logic [2*W-1:0]            d,
    output logic [2*W:0]              rem_re,
    output logic [2*W:0]              rem_im,
    output logic [W:0]                nq_re,
    output logic [W:0]                nq_im,
    output logic [2*W+1:0]            s_lo,
    output logic [W-1:0]              direct_re,
    output logic [W-1:0]              direct_im
);
    import cia_pkg::*;

    localparam int DW = 2 * W;
    localparam int RW = 2 * W + 1;
    localparam int SW = 2 * W + 2;

    // stage A: operand capture
    logic              a_vld_reg;
    cmd_e              a_op_reg;
    logic signed [W-1:0] a_ar_reg, a_ai_reg, a_br_reg, a_bi_reg;

    // stage B: products
    logic                 b_vld_reg;
    cmd_e                 b_op_reg;
    logic signed [DW-1:0] b_rr_reg, b_ii_reg, b_ir_reg, b_ri_reg;
    logic signed [DW-1:0] b_rr_next, b_ii_next, b_ir_next, b_ri_next;
    logic signed [DW-1:0] sq_br_s, sq_bi_s, sq_ar_s, sq_ai_s;
    logic [DW-1:0]        b_sbr_reg, b_sbi_reg, b_sar_reg, b_sai_reg;
    logic [W-1:0]         b_dre_reg, b_dim_reg, b_dre_next, b_dim_next;

    // stage C: sums
    logic                 c_vld_reg;
    cmd_e                 c_op_reg;
    logic signed [DW:0]   c_nr_reg, c_ni_reg;
    logic [DW-1:0]        c_d_reg, c_s_reg;
    logic [W-1:0]         c_dre_reg, c_dim_reg, c_dre_next, c_dim_next;

    // stage D: sign and magnitude
    logic                 d_vld_reg;
    cmd_e                 d_op_reg;
    logic [DW-1:0]        d_mre_reg, d_mim_reg;
    logic [DW:0]          d_tre, d_tim;
    logic                 d_nre_reg, d_nim_reg, d_dz_reg;
    logic [DW-1:0]        d_d_reg, d_s_reg;
    logic [W-1:0]         d_dre_reg, d_dim_reg;

    // stage E: cell chain inputs
    ctl_t                 e_ctl_reg;
    logic [DW-1:0]        e_d_reg;
    logic [RW-1:0]        e_rre_reg, e_rim_reg;
    logic [W:0]           e_nqre_reg, e_nqim_reg;
    logic [SW-1:0]        e_slo_reg;
    logic [W-1:0]         e_dre_reg, e_dim_reg;
    ctl_t                 e_ctl_next;

    always_comb
    begin
        b_rr_next = a_ar_reg * a_br_reg;
        b_ii_next = a_ai_reg * a_bi_reg;
        b_ir_next = a_ai_reg * a_br_reg;
        b_ri_next = a_ar_reg * a_bi_reg;
        sq_br_s   = a_br_reg * a_br_reg;
        sq_bi_s   = a_bi_reg * a_bi_reg;
        sq_ar_s   = a_ar_reg * a_ar_reg;
        sq_ai_s   = a_ai_reg * a_ai_reg;
        unique case (a_op_reg)
            CMD_ADD:
            begin
                b_dre_next = a_ar_reg + a_br_reg;
                b_dim_next = a_ai_reg + a_bi_reg;
            end
            CMD_SUB:
            begin
                b_dre_next = a_ar_reg - a_br_reg;
                b_dim_next = a_ai_reg - a_bi_reg;
            end
            default:
            begin
                b_dre_next = '0;
                b_dim_next = '0;
            end
        endcase
    end

    always_comb
    begin
        c_dre_next = b_dre_reg;
        c_dim_next = b_dim_reg;
        if (b_op_reg == CMD_MUL)
        begin
            c_dre_next = b_rr_reg[W-1:0] - b_ii_reg[W-1:0];
            c_dim_next = b_ri_reg[W-1:0] + b_ir_reg[W-1:0];
        end
    end

    always_comb
    begin
        d_tre = c_nr_reg[DW] ? (~c_nr_reg + 1'b1) : c_nr_reg;
        d_tim = c_ni_reg[DW] ? (~c_ni_reg + 1'b1) : c_ni_reg;
    end

    always_comb
    begin
        e_ctl_next.valid  = d_vld_reg;
        e_ctl_next.op     = d_op_reg;
        e_ctl_next.dz     = d_dz_reg;
        e_ctl_next.neg_re = d_nre_reg;
        e_ctl_next.neg_im = d_nim_reg;
        e_ctl_next.ovf_re = DW'(d_mre_reg[DW-1:W+1]) >= d_d_reg;
        e_ctl_next.ovf_im = DW'(d_mim_reg[DW-1:W+1]) >= d_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_ctl_reg <= '0;
        end
        else if (en)
        begin
            a_vld_reg <= valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_ctl_reg <= e_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg   <= cmd_e'(cmd);
            a_ar_reg   <= ar;
            a_ai_reg   <= ai;
            a_br_reg   <= br;
            a_bi_reg   <= bi;

            b_op_reg   <= a_op_reg;
            b_rr_reg   <= b_rr_next;
            b_ii_reg   <= b_ii_next;
            b_ir_reg   <= b_ir_next;
            b_ri_reg   <= b_ri_next;
            b_sbr_reg  <= sq_br_s;
            b_sbi_reg  <= sq_bi_s;
            b_sar_reg  <= sq_ar_s;
            b_sai_reg  <= sq_ai_s;
            b_dre_reg  <= b_dre_next;
            b_dim_reg  <= b_dim_next;

            c_op_reg   <= b_op_reg;
            c_nr_reg   <= (DW+1)'(b_rr_reg) + (DW+1)'(b_ii_reg);
            c_ni_reg   <= (DW+1)'(b_ir_reg) - (DW+1)'(b_ri_reg);
            c_d_reg    <= b_sbr_reg + b_sbi_reg;
            c_s_reg    <= b_sar_reg + b_sai_reg;
            c_dre_reg  <= c_dre_next;
            c_dim_reg  <= c_dim_next;

            d_op_reg   <= c_op_reg;
            d_mre_reg  <= d_tre[DW-1:0];
            d_mim_reg  <= d_tim[DW-1:0];
            d_nre_reg  <= c_nr_reg[DW];
            d_nim_reg  <= c_ni_reg[DW];
            d_dz_reg   <= (c_d_reg == '0);
            d_d_reg    <= c_d_reg;
            d_s_reg    <= c_s_reg;
            d_dre_reg  <= c_dre_reg;
            d_dim_reg  <= c_dim_reg;

            e_d_reg    <= d_d_reg;
            e_rre_reg  <= RW'(d_mre_reg[DW-1:W+1]);
            e_rim_reg  <= RW'(d_mim_reg[DW-1:W+1]);
            e_nqre_reg <= d_mre_reg[W:0];
            e_nqim_reg <= d_mim_reg[W:0];
            e_slo_reg  <= SW'(d_s_reg);
            e_dre_reg  <= d_dre_reg;
            e_dim_reg  <= d_dim_reg;
        end
    end

    assign ctl       = e_ctl_reg;
    assign d         = e_d_reg;
    assign rem_re    = e_rre_reg;
    assign rem_im    = e_rim_reg;
    assign nq_re     = e_nqre_reg;
    assign nq_im     = e_nqim_reg;
    assign s_lo      = e_slo_reg;
    assign direct_re = e_dre_reg;
    assign direct_im = e_dim_reg;

endmodule

// ----- rtl/core/cia_cell.sv -----
// One cell of the chain: a restoring divide step for each part and a square-root step.
module cia_cell #(
    parameter int W = cia_pkg::CELL_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  cia_pkg::ctl_t     prev_ctl,
    input  logic [2*W-1:0]    prev_d,
    input  logic [2*W:0]      prev_rem_re,
    input  logic [2*W:0]      prev_rem_im,
    input  logic [W:0]        prev_nq_re,
    input  logic [W:0]        prev_nq_im,
    input  logic [2*W+1:0]    prev_s_lo,
    input  logic [W+1:0]      prev_s_rem,
    input  logic [W:0]        prev_root,
    input  logic [W-1:0]      prev_direct_re,
    input  logic [W-1:0]      prev_direct_im,
    output cia_pkg::ctl_t     ctl,
    output logic [2*W-1:0]    d,
    output logic [2*W:0]      rem_re,
    output logic [2*W:0]      rem_im,
    output logic [W:0]        nq_re,
    output logic [W:0]        nq_im,
    output logic [2*W+1:0]    s_lo,
    output logic [W+1:0]      s_rem,
    output logic [W:0]        root,
    output logic [W-1:0]      direct_re,
    output logic [W-1:0]      direct_im
);
    import cia_pkg::*;

    localparam int DW  = 2 * W;
    localparam int RW  = 2 * W + 1;
    localparam int SW  = 2 * W + 2;
    localparam int SRW = W + 2;

    ctl_t           ctl_reg;
    logic [DW-1:0]  d_reg;
    logic [RW-1:0]  rem_re_reg, rem_im_reg, rem_re_next, rem_im_next;
    logic [W:0]     nq_re_reg, nq_im_reg;
    logic [SW-1:0]  s_lo_reg;
    logic [SRW-1:0] s_rem_reg, s_rem_next;
    logic [W:0]     root_reg;
    logic [W-1:0]   dre_reg, dim_reg;

    logic [RW-1:0]  sh_re, sh_im;
    logic           ge_re, ge_im, ge_s;
    logic [W+3:0]   s_sh, s_trial;

    always_comb
    begin
        // bring down the next numerator bit and try the divisor
        sh_re       = {prev_rem_re[RW-2:0], prev_nq_re[W]};
        sh_im       = {prev_rem_im[RW-2:0], prev_nq_im[W]};
        ge_re       = sh_re >= RW'(prev_d);
        ge_im       = sh_im >= RW'(prev_d);
        rem_re_next = ge_re ? sh_re - RW'(prev_d) : sh_re;
        rem_im_next = ge_im ? sh_im - RW'(prev_d) : sh_im;

        // one root digit: try 4*root+1 against the remainder with the next pair
        s_sh        = {prev_s_rem, prev_s_lo[SW-1:SW-2]};
        s_trial     = (W+4)'({prev_root, 2'b01});
        ge_s        = s_sh >= s_trial;
        s_rem_next  = ge_s ? SRW'(s_sh - s_trial) : SRW'(s_sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= prev_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg          <= prev_d;
            rem_re_reg     <= rem_re_next;
            rem_im_reg     <= rem_im_next;
            nq_re_reg      <= {prev_nq_re[W-1:0], ge_re};
            nq_im_reg      <= {prev_nq_im[W-1:0], ge_im};
            s_lo_reg       <= {prev_s_lo[SW-3:0], 2'b00};
            s_rem_reg      <= s_rem_next;
            root_reg       <= {prev_root[W-1:0], ge_s};
            dre_reg        <= prev_direct_re;
            dim_reg        <= prev_direct_im;
        end
    end

    assign ctl       = ctl_reg;
    assign d         = d_reg;
    assign rem_re    = rem_re_reg;
    assign rem_im    = rem_im_reg;
    assign nq_re     = nq_re_reg;
    assign nq_im     = nq_im_reg;
    assign s_lo      = s_lo_reg;
    assign s_rem     = s_rem_reg;
    assign root      = root_reg;
    assign direct_re = dre_reg;
    assign direct_im = dim_reg;

endmodule

// ----- tb/complex_integer_alu_test.sv -----
// Self-checking testbench of the complex integer ALU: directed, random and back-pressure tests.
module complex_integer_alu_test;

    import cia_pkg::*;

    // Settle length for the end of the run: the block's depth plus a margin.
    localparam int SETTLE_CYCLES = CELL_BITS_DEF + 7 + 20;
    // Cycles without any accepted request or result before the run is declared hung.
    localparam int HANG_LIMIT    = 5000;
    // Length of the long receiver hold-off that fills the block.
    localparam int HOLD_CYCLES   = 300;

    localparam logic signed [FIELD_W-1:0] S_MAX = 32'sh7fff_ffff;
    localparam logic signed [FIELD_W-1:0] S_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [FIELD_W-1:0] re;
        logic signed [FIELD_W-1:0] im;
        logic [STATUS_W-1:0]       st;
    } alu_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [CMD_W-1:0]            cmd = '0;
    logic signed [FIELD_W-1:0]   a_real = '0;
    logic signed [FIELD_W-1:0]   a_imag = '0;
    logic signed [FIELD_W-1:0]   b_real = '0;
    logic signed [FIELD_W-1:0]   b_imag = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [FIELD_W-1:0]   res_real;
    logic signed [FIELD_W-1:0]   res_imag;
    logic [STATUS_W-1:0]         status;

    alu_result_t pending_results[$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          stall_pct      = 0;
    int          quiet_cycles   = 0;

    // Hold-off handshake between the tests and the stall process
    logic hold_go  = 1'b0;
    logic hold_ack = 1'b0;
    int   hold_left = 0;

    complex_integer_alu i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .a_real    (a_real),
        .a_imag    (a_imag),
        .b_real    (b_real),
        .b_imag    (b_imag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_real  (res_real),
        .res_imag  (res_imag),
        .status    (status)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round one quotient part to nearest, ties away from zero, then saturate to 32 bits.
    function automatic logic [FIELD_W-1:0] round_quotient(input logic signed [127:0] num,
                                                          input logic [127:0] den,
                                                          inout logic sat);
        logic          neg;
        logic [127:0]  mag;
        logic [127:0]  q;
        logic [127:0]  r;
        logic [127:0]  lim;
        neg = num < 0;
        mag = neg ? 128'(-num) : 128'(num);
        q   = mag / den;
        r   = mag % den;
        if (r >= den - r)
            q = q + 1;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim)
        begin
            q   = lim;
            sat = 1'b1;
        end
        return neg ? -q[FIELD_W-1:0] : q[FIELD_W-1:0];
    endfunction

    // Integer square root rounded to nearest.
    function automatic logic [63:0] rounded_root(input logic [63:0] s);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = s;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        if (s - root * root > root)
            root = root + 1;
        return root;
    endfunction

    function automatic alu_result_t compute_result(input logic [CMD_W-1:0] op,
                                                   input logic signed [FIELD_W-1:0] ar,
                                                   input logic signed [FIELD_W-1:0] ai,
                                                   input logic signed [FIELD_W-1:0] br,
                                                   input logic signed [FIELD_W-1:0] bi);
        alu_result_t       res;
        logic signed [127:0] xar;
        logic signed [127:0] xai;
        logic signed [127:0] xbr;
        logic signed [127:0] xbi;
        logic [127:0]      den;
        logic [63:0]       root;
        logic              sat;
        res = '{re: '0, im: '0, st: ST_OK};
        xar = ar;
        xai = ai;
        xbr = br;
        xbi = bi;
        sat = 1'b0;
        case (op)
            CMD_ADD:
            begin
                res.re = ar + br;
                res.im = ai + bi;
            end
            CMD_SUB:
            begin
                res.re = ar - br;
                res.im = ai - bi;
            end
            CMD_MUL:
            begin
                res.re = ar * br - ai * bi;
                res.im = ar * bi + ai * br;
            end
            CMD_DIV:
            begin
                if (br == 0 && bi == 0)
                    res.st = ST_DIVZ;
                else
                begin
                    den    = 128'(xbr * xbr + xbi * xbi);
                    res.re = round_quotient(xar * xbr + xai * xbi, den, sat);
                    res.im = round_quotient(xai * xbr - xar * xbi, den, sat);
                    res.st = sat ? ST_SAT : ST_OK;
                end
            end
            CMD_MAG:
            begin
                root = rounded_root(64'(xar * xar + xai * xai));
                if (root > 64'h7fff_ffff)
                begin
                    root   = 64'h7fff_ffff;
                    res.st = ST_SAT;
                end
                res.re = root[FIELD_W-1:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver, receiver stall and result checker
    // ------------------------------------------------------------------

    // Offer one request, idling first at the current rate; hold it until accepted.
    // Valid is left high on return, so back-to-back requests follow without a gap.
    task automatic send_request(input logic [CMD_W-1:0] op,
                                input logic signed [FIELD_W-1:0] ar,
                                input logic signed [FIELD_W-1:0] ai,
                                input logic signed [FIELD_W-1:0] br,
                                input logic signed [FIELD_W-1:0] bi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        a_real   <= ar;
        a_imag   <= ai;
        b_real   <= br;
        b_imag   <= bi;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(compute_result(op, ar, ai, br, bi));
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("result %s: got %0d, want %0d", field, got, want);
        mismatch_count++;
    endtask

    // Stall the result channel at the current rate, or for a whole hold-off when asked
    always @(posedge clk)
    begin
        if (hold_go != hold_ack)
        begin
            hold_ack  <= hold_go;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        alu_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("with no request outstanding, res_real", res_real, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_real !== want.re)
                    report_mismatch("res_real", res_real, want.re);
                if (res_imag !== want.im)
                    report_mismatch("res_imag", res_imag, want.im);
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mix of full-range, small, half-width and boundary operand parts
    function automatic logic signed [FIELD_W-1:0] pick_operand();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2:    return $signed($urandom_range(200)) - 100;
            3:    return $signed({{16{$urandom_range(1) == 1}}, 16'($urandom)});
            4:
            begin
                case ($urandom_range(4))
                    0:       return S_MAX;
                    1:       return S_MIN;
                    2:       return 0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
            default: return $signed($urandom_range(3000)) - 1500;
        endcase
    endfunction

    task automatic send_random(input int count);
        logic [CMD_W-1:0]          op;
        logic signed [FIELD_W-1:0] br;
        logic signed [FIELD_W-1:0] bi;
        for (int n = 0; n < count; n++)
        begin
            // mostly the five operations, now and then an unused code
            op = ($urandom_range(19) == 0) ? CMD_W'($urandom_range(7, 5))
                                            : CMD_W'($urandom_range(4));
            br = pick_operand();
            bi = pick_operand();
            if (op == CMD_DIV && $urandom_range(9) == 0)
            begin
                br = 0;
                bi = 0;
            end
            send_request(op, pick_operand(), pick_operand(), br, bi);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        // wrap on add, subtract and multiply
        send_request(CMD_ADD, S_MAX, S_MIN, 1, -1);
        send_request(CMD_SUB, S_MIN, S_MAX, 1, -1);
        send_request(CMD_MUL, S_MIN, S_MIN, S_MIN, S_MIN);
        send_request(CMD_MUL, S_MAX, -1, S_MAX, S_MAX);
        // divide by zero
        send_request(CMD_DIV, 7, -9, 0, 0);
        send_request(CMD_DIV, 0, 0, 0, 0);
        // rounding to nearest, with ties away from zero
        send_request(CMD_DIV, 5, -5, 2, 0);
        send_request(CMD_DIV, 1, 1, 0, 2);
        send_request(CMD_DIV, 7, 3, 1, 1);
        send_request(CMD_DIV, 100, -37, -3, 4);
        // divide overflow saturates, beside extreme operands that do not overflow
        send_request(CMD_DIV, S_MIN, 0, -1, 0);
        send_request(CMD_DIV, S_MIN, S_MIN, 1, -1);
        send_request(CMD_DIV, S_MAX, S_MAX, 1, 1);
        send_request(CMD_DIV, 1, 0, S_MIN, S_MIN);
        // magnitude, b ignored
        send_request(CMD_MAG, 3, -4, S_MAX, S_MIN);
        send_request(CMD_MAG, 1, 1, 0, 0);
        send_request(CMD_MAG, 0, 0, 5, 5);
        send_request(CMD_MAG, S_MAX, 0, 0, 0);
        send_request(CMD_MAG, S_MIN, 0, 0, 0);
        send_request(CMD_MAG, S_MIN, S_MIN, 0, 0);
        // unused command codes give zeros
        send_request(CMD_W'(5), S_MAX, S_MIN, -1, 1);
        send_request(CMD_W'(6), -1, -1, -1, -1);
        send_request(CMD_W'(7), S_MIN, S_MAX, S_MIN, S_MAX);
        drain_results();
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_random(200);
        send_idle_pct = 75;
        stall_pct     = 0;
        send_random(200);
        send_idle_pct = 0;
        stall_pct     = 75;
        send_random(200);
        send_idle_pct = 26;
        stall_pct     = 26;
        send_random(170);
    endtask

    // Hold the result channel off long enough that the block fills and stalls its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_go      <= ~hold_go;
        send_random(80);
    endtask

    // Pause the sender until everything is back, then resume
    task automatic test_drain_pause();
        drain_results();
        send_idle_pct = 10;
        stall_pct     = 10;
        send_random(20);
        drain_results();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phases();
        test_backpressure();
        test_drain_pause();

        // allow any stray result to surface before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
